// File: design/rle_pkg.sv
// Package for the interleaved RLE bitmap decoder: codes, phases and helpers.
// No dependencies.
package rle_pkg;

   localparam int MaxWidthDefault = 256;

   typedef enum logic [1:0] {
      OP_FEED  = 2'd0,
      OP_PIXEL = 2'd1,
      OP_START = 2'd2,
      OP_NONE3 = 2'd3
   } operation_type;

   typedef enum logic [2:0] {
      ST_PIXEL   = 3'd0,
      ST_TAKEN   = 3'd1,
      ST_NEEDED  = 3'd2,
      ST_REFUSED = 3'd3,
      ST_ERROR   = 3'd4
   } status_type;

   typedef enum logic [9:0] {
      PH_HEAD  = 10'b00_0000_0001,
      PH_CNT1  = 10'b00_0000_0010,
      PH_CNTLO = 10'b00_0000_0100,
      PH_CNTHI = 10'b00_0000_1000,
      PH_COL1  = 10'b00_0001_0000,
      PH_COL2  = 10'b00_0010_0000,
      PH_MIX   = 10'b00_0100_0000,
      PH_RUN   = 10'b00_1000_0000,
      PH_MASK  = 10'b01_0000_0000,
      PH_COPY  = 10'b10_0000_0000
   } phase_type;

   // order codes after header decode
   localparam logic [3:0] ORD_FILL    = 4'd0;
   localparam logic [3:0] ORD_MIX     = 4'd1;
   localparam logic [3:0] ORD_FOM     = 4'd2;
   localparam logic [3:0] ORD_COLOR   = 4'd3;
   localparam logic [3:0] ORD_COPY    = 4'd4;
   localparam logic [3:0] ORD_SET_MIX = 4'd6;
   localparam logic [3:0] ORD_SET_FOM = 4'd7;
   localparam logic [3:0] ORD_BICOLOR = 4'd8;
   localparam logic [3:0] ORD_FOM_M3  = 4'd9;
   localparam logic [3:0] ORD_FOM_M5  = 4'd10;
   localparam logic [3:0] ORD_WHITE   = 4'd13;
   localparam logic [3:0] ORD_BLACK   = 4'd14;

   localparam logic [4:0] PrevNone = 5'h1f;

   localparam logic [1:0] CSR_BPP    = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   function automatic logic [23:0] pix_mask(input logic [1:0] bpp);
      logic [23:0] m;
      case (bpp)
         2'd1:    m = 24'h0000ff;
         2'd2:    m = 24'h00ffff;
         default: m = 24'hffffff;
      endcase
      return m;
   endfunction

endpackage

// File: design/rle_bitmap_decoder_core.sv
// Top level of the interleaved RLE bitmap decoder.
// Uses rle_pkg and rle_line_store.
//
// Every request (feed a byte, ask for a pixel, start a bitmap) is answered by
// exactly one response transfer. When a request is accepted, the decode
// state and the response register both load at that accepting edge, and the
// response is offered from the next cycle on. A new request may be taken
// every cycle while the response register is empty or being drained, so
// throughput is one transfer per clock. The previous-row value for the pixel
// about to be given is fetched from the line store one step ahead: after each
// accepted request the store is read at the then current column, so the
// registered read is ready by the next request. A write to the same column
// bypasses the read. Configuration may only be changed while idle.
module rle_bitmap_decoder_core #(
   parameter int MAX_WIDTH = rle_pkg::MaxWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [23:0] rsp_pixel,
   output logic [15:0] rsp_row,
   output logic [7:0]  rsp_column,
   output logic        rsp_frame_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import rle_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam logic [9:0] MaxW = 10'(MAX_WIDTH > 511 ? 511 : MAX_WIDTH);

   // configuration
   logic [1:0]  bpp_ff;
   logic [8:0]  width_ff;
   logic [15:0] height_ff;

   // decode state
   logic [9:0]  col_ff, col_in;
   logic [15:0] rows_ff, rows_in;
   logic        first_ff, first_in, started_ff, started_in;
   logic [16:0] run_ff, run_in;
   logic [3:0]  cop_ff, cop_in;
   logic [4:0]  pop_ff, pop_in;
   phase_type   ph_ff, ph_in;
   logic [23:0] gat_ff, gat_in;
   logic [1:0]  gidx_ff, gidx_in;
   logic [23:0] mix_ff, mix_in, c1_ff, c1_in, c2_ff, c2_in;
   logic [7:0]  mbyte_ff, mbyte_in;
   logic [8:0]  mbit_ff, mbit_in;
   logic [2:0]  fmask_ff, fmask_in;
   logic        ins_ff, ins_in, bic_ff, bic_in, err_ff, err_in;

   // response register
   logic [2:0]  st_ff, st_in;
   logic [23:0] px_ff, px_in;
   logic [15:0] row_ff, row_in;
   logic [7:0]  colo_ff, colo_in;
   logic        fd_ff, fd_in;
   logic        rv_ff;

   // line store
   logic            ls_we;
   logic [AW-1:0]   ls_waddr, ls_raddr;
   logic [23:0]     ls_wdata, ls_rdata;
   logic            byp_ff;
   logic [23:0]     bypd_ff;
   logic [23:0]     prev_val;

   logic accept;
   assign req_ready = !rv_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // effective width, clamped to the store depth
   logic [9:0] w_eff;
   assign w_eff = ({1'b0, width_ff} > MaxW) ? MaxW : {1'b0, width_ff};

   rle_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_store (
      .clock  (clock),
      .wr_en  (ls_we),
      .wr_addr(ls_waddr),
      .wr_data(ls_wdata),
      .rd_addr(ls_raddr),
      .rd_data(ls_rdata)
   );

   assign prev_val = byp_ff ? bypd_ff : ls_rdata;

   always_comb begin
      logic [3:0]  hi, op;
      logic [16:0] cnt;
      logic        shortf, fom, gdone, dec, do_settle, do_finish, do_after;
      logic [23:0] prev, pix, gnew;
      logic [1:0]  gnext;
      col_in = col_ff; rows_in = rows_ff; first_in = first_ff;
      started_in = started_ff; run_in = run_ff; cop_in = cop_ff; pop_in = pop_ff;
      ph_in = ph_ff; gat_in = gat_ff; gidx_in = gidx_ff; mix_in = mix_ff;
      c1_in = c1_ff; c2_in = c2_ff; mbyte_in = mbyte_ff; mbit_in = mbit_ff;
      fmask_in = fmask_ff; ins_in = ins_ff; bic_in = bic_ff; err_in = err_ff;
      st_in = ST_TAKEN; px_in = '0; row_in = '0; colo_in = '0; fd_in = 1'b0;
      ls_we = 1'b0; ls_waddr = AW'(col_ff); ls_wdata = '0;
      hi = req_data_byte[7:4]; op = '0; cnt = '0; shortf = 1'b1; fom = 1'b0;
      gdone = 1'b0; dec = 1'b1; do_settle = 1'b0; do_finish = 1'b0;
      do_after = 1'b0; prev = '0; pix = '0; gnext = '0;
      gnew = gat_ff | (24'(req_data_byte) << {gidx_ff, 3'b000});
      gnext = gidx_ff + 2'd1;

      if (req_operation == OP_NONE3) begin
         st_in = ST_REFUSED;
      end else if (req_operation == OP_START) begin
         col_in = w_eff; rows_in = height_ff; first_in = 1'b1; started_in = 1'b0;
         run_in = '0; cop_in = ORD_FILL; pop_in = PrevNone; ph_in = PH_HEAD;
         gat_in = '0; gidx_in = '0; mix_in = 24'hffffff; c1_in = '0; c2_in = '0;
         mbyte_in = '0; mbit_in = '0; fmask_in = '0; ins_in = 1'b0;
         bic_in = 1'b0; err_in = 1'b0; st_in = ST_TAKEN;
      end else if (err_ff) begin
         st_in = ST_ERROR;
      end else if (bpp_ff == 2'd0) begin
         err_in = 1'b1; st_in = ST_ERROR;
      end else if (req_operation == OP_FEED) begin
         // gather helper
         if (gnext >= bpp_ff) begin
            gdone = 1'b1; gnext = '0;
         end
         unique case (ph_ff)
            PH_HEAD: begin
               fmask_in = '0;
               if (hi >= 4'hc && hi <= 4'he) begin
                  op = hi - 4'd6; cnt = 17'(req_data_byte[3:0]);
               end else if (hi == 4'hf) begin
                  op = req_data_byte[3:0];
                  cnt = (op < 4'hb) ? 17'd8 : 17'd1;
                  shortf = 1'b0;
               end else begin
                  op = {1'b0, hi[3:1]}; cnt = 17'(req_data_byte[4:0]);
               end
               cop_in = op;
               if (hi == 4'hf && op < 4'd9) begin
                  ph_in = PH_CNTLO;
               end else if (shortf && cnt == '0) begin
                  ph_in = PH_CNT1;
               end else begin
                  fom = (op == ORD_FOM || op == ORD_SET_FOM);
                  run_in = (shortf && fom) ? (cnt << 3) : cnt;
                  do_after = 1'b1;
               end
            end
            PH_CNT1: begin
               fom = (cop_ff == ORD_FOM || cop_ff == ORD_SET_FOM);
               run_in = fom ? 17'(req_data_byte) + 17'd1 :
                  17'(req_data_byte) + ((cop_ff >= ORD_SET_MIX) ? 17'd16 : 17'd32);
               do_after = 1'b1;
            end
            PH_CNTLO: begin
               run_in = 17'(req_data_byte); ph_in = PH_CNTHI;
            end
            PH_CNTHI: begin
               run_in = {1'b0, req_data_byte, run_ff[7:0]};
               do_after = 1'b1;
            end
            PH_COL1: begin
               gat_in = gnew; gidx_in = gnext;
               if (gdone) begin
                  c1_in = gnew & pix_mask(bpp_ff); gat_in = '0; ph_in = PH_COL2;
               end
            end
            PH_COL2: begin
               gat_in = gnew; gidx_in = gnext;
               if (gdone) begin
                  c2_in = gnew & pix_mask(bpp_ff); do_finish = 1'b1;
               end
            end
            PH_MIX: begin
               gat_in = gnew; gidx_in = gnext;
               if (gdone) begin
                  mix_in = gnew & pix_mask(bpp_ff); do_finish = 1'b1;
               end
            end
            PH_MASK: begin
               mbyte_in = req_data_byte; mbit_in = 9'd1; ph_in = PH_RUN;
            end
            PH_COPY: begin
               gat_in = gnew; gidx_in = gnext;
               if (gdone) ph_in = PH_RUN;
            end
            default: st_in = ST_REFUSED;
         endcase
         if (do_after) begin
            gat_in = '0; gidx_in = '0;
            if (cop_in == ORD_BICOLOR) ph_in = PH_COL1;
            else if (cop_in == ORD_COLOR) ph_in = PH_COL2;
            else if (cop_in == ORD_SET_MIX || cop_in == ORD_SET_FOM) ph_in = PH_MIX;
            else do_finish = 1'b1;
         end
      end else if (ph_ff != PH_RUN) begin
         st_in = ST_NEEDED;
      end else begin
         // emit one pixel
         prev = first_ff ? 24'd0 : prev_val;
         case (cop_ff)
            ORD_FILL: begin
               pix = ins_ff ? (prev ^ mix_ff) : prev; ins_in = 1'b0;
            end
            ORD_MIX: pix = prev ^ mix_ff;
            ORD_FOM: pix = ((mbyte_ff & mbit_ff[7:0]) != '0) ? (prev ^ mix_ff) : prev;
            ORD_COLOR: pix = c2_ff;
            ORD_COPY: pix = gat_ff;
            ORD_BICOLOR: begin
               if (bic_ff) begin
                  pix = c2_ff; bic_in = 1'b0;
               end else begin
                  pix = c1_ff; bic_in = 1'b1; dec = 1'b0;
               end
            end
            ORD_WHITE: pix = 24'hffffff;
            default: pix = '0;
         endcase
         pix = pix & pix_mask(bpp_ff);
         ls_we = (32'(col_ff) < MAX_WIDTH); ls_wdata = pix;
         st_in = ST_PIXEL; px_in = pix; row_in = rows_ff; colo_in = col_ff[7:0];
         fd_in = (rows_ff == '0) && (col_ff + 10'd1 == w_eff);
         col_in = col_ff + 10'd1;
         if (dec) run_in = run_ff - 17'd1;
         do_settle = 1'b1;
      end

      if (do_finish) begin
         op = cop_in;
         case (op)
            ORD_FILL:
               if (pop_ff == {1'b0, ORD_FILL} && !(col_in == w_eff && first_in))
                  ins_in = 1'b1;
            ORD_SET_MIX, ORD_SET_FOM: op = op - 4'd5;
            ORD_FOM_M3: begin
               mbyte_in = 8'h03; op = ORD_FOM; fmask_in = 3'd3;
            end
            ORD_FOM_M5: begin
               mbyte_in = 8'h05; op = ORD_FOM; fmask_in = 3'd5;
            end
            default: ;
         endcase
         cop_in = op; pop_in = {1'b0, op}; mbit_in = '0;
         do_settle = 1'b1;
      end

      if (do_settle) begin
         if (run_in == '0) begin
            ph_in = PH_HEAD;
         end else if (!(cop_in <= ORD_COPY || cop_in == ORD_BICOLOR ||
                        cop_in == ORD_WHITE || cop_in == ORD_BLACK)) begin
            err_in = 1'b1;
         end else if (col_in >= w_eff && (w_eff == '0 || rows_in == '0)) begin
            err_in = 1'b1;
         end else begin
            if (col_in >= w_eff) begin
               col_in = '0; rows_in = rows_in - 16'd1;
               if (started_in) first_in = 1'b0;
               started_in = 1'b1;
            end
            if (cop_in == ORD_COPY) begin
               ph_in = PH_COPY; gat_in = '0; gidx_in = '0;
            end else begin
               ph_in = PH_RUN;
               if (cop_in == ORD_FOM) begin
                  mbit_in = {mbit_in[7:0], 1'b0};
                  if (mbit_in[7:0] == '0) begin
                     if (fmask_in != '0) begin
                        mbyte_in = {5'd0, fmask_in}; mbit_in = 9'd1;
                     end else begin
                        ph_in = PH_MASK;
                     end
                  end
               end
            end
         end
      end

      if (req_operation == OP_FEED && st_in == ST_TAKEN && err_in) st_in = ST_ERROR;
      if (!accept) ls_we = 1'b0;
   end

   // read ahead at the column that the next request will use
   assign ls_raddr = accept ? AW'(col_in) : AW'(col_ff);

   always_ff @(posedge clock) begin
      byp_ff  <= ls_we && (ls_waddr == ls_raddr);
      bypd_ff <= ls_wdata;
      if (accept) begin
         px_ff <= px_in; row_ff <= row_in; colo_ff <= colo_in; fd_ff <= fd_in;
         st_ff <= st_in;
      end
      if (reset) begin
         bpp_ff <= 2'd1; width_ff <= 9'd64; height_ff <= 16'd64;
         col_ff <= 10'd64 > MaxW ? MaxW : 10'd64; rows_ff <= 16'd64;
         first_ff <= 1'b1; started_ff <= 1'b0; run_ff <= '0; cop_ff <= ORD_FILL;
         pop_ff <= PrevNone; ph_ff <= PH_HEAD; gat_ff <= '0; gidx_ff <= '0;
         mix_ff <= 24'hffffff; c1_ff <= '0; c2_ff <= '0; mbyte_ff <= '0;
         mbit_ff <= '0; fmask_ff <= '0; ins_ff <= 1'b0; bic_ff <= 1'b0;
         err_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_BPP:    bpp_ff <= csr_data[1:0];
               CSR_WIDTH:  width_ff <= csr_data[8:0];
               CSR_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            col_ff <= col_in; rows_ff <= rows_in; first_ff <= first_in;
            started_ff <= started_in; run_ff <= run_in; cop_ff <= cop_in;
            pop_ff <= pop_in; ph_ff <= ph_in; gat_ff <= gat_in; gidx_ff <= gidx_in;
            mix_ff <= mix_in; c1_ff <= c1_in; c2_ff <= c2_in; mbyte_ff <= mbyte_in;
            mbit_ff <= mbit_in; fmask_ff <= fmask_in; ins_ff <= ins_in;
            bic_ff <= bic_in; err_ff <= err_in;
            rv_ff <= 1'b1;
         end else if (rsp_ready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = st_ff;
   assign rsp_pixel      = px_ff;
   assign rsp_row        = row_ff;
   assign rsp_column     = colo_ff;
   assign rsp_frame_done = fd_ff;
endmodule

// File: design/rle_line_store.sv
// One-row line store of the RLE decoder: previous row pixels.
// Depends on nothing but its parameters.
module rle_line_store #(
   parameter int MAX_WIDTH = 256
) (
   input  logic                                             clock,
   input  logic                                             wr_en,
   input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] wr_addr,
   input  logic [23:0]                                      wr_data,
   input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] rd_addr,
   output logic [23:0]                                      rd_data
);
   logic [23:0] mem [MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: design/rle_checker.sv
// Port-level checks of the RLE decoder, bound to the top level.
// Depends on rle_pkg.
module rle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_operation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [23:0] rsp_pixel,
   input logic        rsp_frame_done
);
   import rle_pkg::*;

   // an accepted request always yields a response next cycle
   a_resp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid) else $error("no response");

   // start always answers byte taken
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_START |=> rsp_status == ST_TAKEN)
      else $error("start status");

   // non-pixel results carry zero payload
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_PIXEL |-> rsp_pixel == '0 && !rsp_frame_done)
      else $error("payload not zero");

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped");
endmodule

bind rle_bitmap_decoder_core rle_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_operation(req_operation), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_status(rsp_status), .rsp_pixel(rsp_pixel), .rsp_frame_done(rsp_frame_done)
);
